FILE: hdl/mle_pkg.sv
// Package for the instruction executor: operation and status codes, queue beat type.
// No dependencies.
package mle_pkg;

  localparam int unsigned PcBitsDef  = 16;
  localparam int unsigned NumRegsDef = 32;
  localparam int unsigned PcOutBits  = 16;

  localparam logic [4:0] RegService  = 5'd2;
  localparam logic [4:0] RegArgument = 5'd4;
  localparam logic [4:0] RegLink     = 5'd31;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_LI = 5'd1, OP_ADD = 5'd2, OP_ADDI = 5'd3, OP_ADDU = 5'd4,
    OP_ADDIU = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_MOVE = 5'd9,
    OP_SUBI = 5'd10, OP_MULI = 5'd11, OP_DIVI = 5'd12, OP_J = 5'd13, OP_JR = 5'd14,
    OP_JAL = 5'd15, OP_SYSCALL = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_SYSCALL = 2'd1, ST_UNKNOWN = 2'd2, ST_DIVZERO = 2'd3
  } status_e;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic        known;
    logic [4:0]  op;
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [31:0] imm;
    logic [15:0] jt;
  } instr_t;

endpackage

FILE: hdl/mle_front.sv
// Front end: accepts instruction beats, classifies them, holds them in a two-entry queue.
// Depends on mle_pkg.
module mle_front import mle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [4:0]  operation_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src_a_reg_i,
  input  logic [4:0]  src_b_reg_i,
  input  logic [31:0] immediate_i,
  input  logic [15:0] jump_target_i,
  output logic        q_valid_o,
  output instr_t      q_data_o,
  input  logic        q_take_i
);

  instr_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;
  instr_t     in_w;

  // Classification of the incoming beat
  always_comb begin
    in_w       = '0;
    in_w.known = (operation_i <= OP_SYSCALL);
    in_w.op    = operation_i;
    in_w.dest  = dest_reg_i;
    in_w.src_a = src_a_reg_i;
    in_w.src_b = src_b_reg_i;
    in_w.imm   = immediate_i;
    in_w.jt    = jump_target_i;
  end

  assign full_o    = cnt_q[1];
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];
  assign wr        = push_i && !full_o;
  assign rd        = q_take_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= in_w;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("front queue overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !wr) else $error("write into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");
`endif

endmodule

FILE: hdl/mle_divider.sv
// Serial signed 32-bit divider, one quotient bit a cycle, truncates toward zero.
// Depends on mle_pkg.
module mle_divider import mle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, quo_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        neg_q, busy_q, done_q;
  logic [32:0] trial;

  assign trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = neg_q ? (32'd0 - quo_q) : quo_q;

  // Restoring division loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
        rem_q  <= '0;
        quo_q  <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
        dvs_q  <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
        neg_q  <= dividend_i[31] ^ divisor_i[31];
      end else if (busy_q) begin
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= 6'd31) else $error("divider count");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("start lost");
`endif

endmodule

FILE: hdl/mle_back.sv
// Back end: register file, program counter, execute and one-entry result register.
// Depends on mle_pkg and mle_divider.
module mle_back import mle_pkg::*; #(
  parameter int unsigned PC_BITS  = PcBitsDef,
  parameter int unsigned NUM_REGS = NumRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  instr_t      q_data_i,
  output logic        q_take_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  status_o,
  output logic [15:0] next_pc_o,
  output logic        wrote_register_o,
  output logic [4:0]  written_index_o,
  output logic [31:0] written_value_o,
  output logic [31:0] service_code_o,
  output logic [31:0] service_argument_o
);

  localparam int unsigned IdxBits = $clog2(NUM_REGS);

  typedef enum logic [1:0] {S_EXEC, S_DIV} state_e;

  state_e              state_q;
  logic [31:0]         rf_q [NUM_REGS];
  logic [PC_BITS-1:0]  pc_q, seq;
  logic                out_v_q;
  logic [1:0]          st_d;
  logic [PC_BITS-1:0]  npc_d;
  logic                wr_d;
  logic [4:0]          widx_d;
  logic [31:0]         wval_d, sc_d, sa_d, ra, rb, divisor, mul_b;
  logic [31:0]         prod;
  logic                is_div, div_start, div_done, slot_free;
  logic [31:0]         div_q;
  logic [1:0]          st_q;
  logic [PC_BITS-1:0]  npc_q;
  logic                wr_q;
  logic [4:0]          widx_q;
  logic [31:0]         wval_q, sc_q, sa_q;
  instr_t              in;

  assign in        = q_data_i;
  assign ra        = rf_q[in.src_a[IdxBits-1:0]];
  assign rb        = rf_q[in.src_b[IdxBits-1:0]];
  assign seq       = pc_q + {{(PC_BITS-1){1'b0}}, 1'b1};
  assign is_div    = in.known && (in.op == OP_DIV || in.op == OP_DIVI);
  assign divisor   = (in.op == OP_DIV) ? rb : in.imm;
  assign mul_b     = (in.op == OP_MUL) ? rb : in.imm;
  assign prod      = ra * mul_b;
  assign slot_free = !out_v_q || pop_i;
  assign div_start = (state_q == S_EXEC) && q_valid_i && is_div && divisor != 32'd0
                     && slot_free;

  mle_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(ra), .divisor_i(divisor),
    .done_o(div_done), .quot_o(div_q)
  );

  // Execute one instruction
  always_comb begin
    st_d   = ST_DONE;
    npc_d  = seq;
    wr_d   = 1'b0;
    widx_d = '0;
    wval_d = '0;
    sc_d   = '0;
    sa_d   = '0;
    if (!in.known) begin
      st_d  = ST_UNKNOWN;
      npc_d = pc_q;
    end else begin
      unique case (op_e'(in.op))
        OP_NOP: ;
        OP_LI: begin wr_d = 1'b1; widx_d = in.dest; wval_d = in.imm; end
        OP_ADD, OP_ADDU: begin wr_d = 1'b1; widx_d = in.dest; wval_d = ra + rb; end
        OP_ADDI, OP_ADDIU: begin wr_d = 1'b1; widx_d = in.dest; wval_d = ra + in.imm; end
        OP_SUB: begin wr_d = 1'b1; widx_d = in.dest; wval_d = ra - rb; end
        OP_SUBI: begin wr_d = 1'b1; widx_d = in.dest; wval_d = ra - in.imm; end
        OP_MUL, OP_MULI: begin wr_d = 1'b1; widx_d = in.dest; wval_d = prod; end
        OP_MOVE: begin wr_d = 1'b1; widx_d = in.dest; wval_d = ra; end
        OP_DIV, OP_DIVI: begin
          if (divisor == 32'd0) begin
            st_d  = ST_DIVZERO;
            npc_d = pc_q;
          end else begin
            wr_d = 1'b1; widx_d = in.dest; wval_d = div_q;
          end
        end
        OP_J: npc_d = PC_BITS'(in.jt);
        OP_JR: npc_d = ra[PC_BITS-1:0];
        OP_JAL: begin
          wr_d   = 1'b1;
          widx_d = RegLink;
          wval_d = 32'(seq);
          npc_d  = (in.src_a == RegLink) ? seq : ra[PC_BITS-1:0];
        end
        OP_SYSCALL: begin
          st_d = ST_SYSCALL;
          sc_d = rf_q[RegService];
          sa_d = rf_q[RegArgument];
        end
        default: ;
      endcase
    end
  end

  // Retire: fast ops and zero-divisor divides when slot free in EXEC, other divides when divider finishes
  logic retire;
  assign retire = q_valid_i && slot_free &&
                  ((state_q == S_EXEC && !(is_div && divisor != 32'd0)) ||
                   (state_q == S_DIV && div_done));
  assign q_take_o = retire;

  // Architectural state, control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EXEC;
      pc_q    <= '0;
      out_v_q <= 1'b0;
      st_q    <= ST_DONE;
      npc_q   <= '0;
      wr_q    <= 1'b0;
      widx_q  <= '0;
      wval_q  <= '0;
      sc_q    <= '0;
      sa_q    <= '0;
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
    end else begin
      if (div_start) state_q <= S_DIV;
      else if (state_q == S_DIV && div_done) state_q <= S_EXEC;
      if (retire) begin
        pc_q    <= npc_d;
        out_v_q <= 1'b1;
        st_q    <= st_d;
        npc_q   <= npc_d;
        wr_q    <= wr_d;
        widx_q  <= widx_d;
        wval_q  <= wval_d;
        sc_q    <= sc_d;
        sa_q    <= sa_d;
        if (wr_d) rf_q[widx_d[IdxBits-1:0]] <= wval_d;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign empty_o            = !out_v_q;
  assign status_o           = st_q;
  assign next_pc_o          = 16'(npc_q);
  assign wrote_register_o   = wr_q;
  assign written_index_o    = widx_q;
  assign written_value_o    = wval_q;
  assign service_code_o     = sc_q;
  assign service_argument_o = sa_q;

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> q_valid_i) else $error("divide lost its instruction");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |-> !retire) else $error("result overwritten");
  a_jal_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && in.known && in.op == OP_JAL) |=> rf_q[RegLink] == 32'($past(seq)))
    else $error("jal link wrong");
`endif

endmodule

FILE: hdl/mips_like_instruction_executor.sv
// Instruction executor: 32 x 32-bit register file and program counter, one result per
// instruction. Most instructions execute directly in the back end; div and divi with a
// nonzero divisor wait for the bit-serial divider (32 steps plus start and finish). A
// two-entry queue sits between the decode front and the execute back end.
// Depends on mle_pkg, mle_front, mle_back.
module mips_like_instruction_executor import mle_pkg::*; #(
  parameter int unsigned PC_BITS  = PcBitsDef,
  parameter int unsigned NUM_REGS = NumRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  operation_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  src_a_reg_i,
  input  logic [4:0]  src_b_reg_i,
  input  logic [31:0] immediate_i,
  input  logic [15:0] jump_target_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [15:0] next_pc_o,
  output logic        wrote_register_o,
  output logic [4:0]  written_index_o,
  output logic [31:0] written_value_o,
  output logic [31:0] service_code_o,
  output logic [31:0] service_argument_o
);

  logic   q_valid, q_take;
  instr_t q_data;

  mle_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .operation_i, .dest_reg_i,
    .src_a_reg_i, .src_b_reg_i, .immediate_i, .jump_target_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_take_i(q_take)
  );

  mle_back #(.PC_BITS(PC_BITS), .NUM_REGS(NUM_REGS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_take_o(q_take),
    .empty_o(empty), .pop_i(pop), .status_o, .next_pc_o, .wrote_register_o,
    .written_index_o, .written_value_o, .service_code_o, .service_argument_o
  );

endmodule

FILE: tb/tb_mips_like_instruction_executor.sv
// Testbench for the instruction executor: directed and random instruction streams,
// a behavioural predictor of register file and program counter, per-field checking.
// Depends on mle_pkg and mips_like_instruction_executor.
`timescale 1ns / 1ps
module tb_mips_like_instruction_executor;
  import mle_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 80;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] next_pc;
    logic        wrote;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] scode;
    logic [31:0] sarg;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [4:0]  operation_i = '0, dest_reg_i = '0, src_a_reg_i = '0, src_b_reg_i = '0;
  logic [31:0] immediate_i = '0;
  logic [15:0] jump_target_i = '0;
  logic [1:0]  status_o;
  logic [15:0] next_pc_o;
  logic        wrote_register_o;
  logic [4:0]  written_index_o;
  logic [31:0] written_value_o, service_code_o, service_argument_o;

  // Predictor state
  logic [31:0]  shadow_regs [32];
  logic [15:0]  shadow_pc;
  exec_result_t pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;

  mips_like_instruction_executor dut (
    .clk_i, .rst_ni, .push, .full, .operation_i, .dest_reg_i, .src_a_reg_i,
    .src_b_reg_i, .immediate_i, .jump_target_i, .empty, .pop, .status_o, .next_pc_o,
    .wrote_register_o, .written_index_o, .written_value_o, .service_code_o,
    .service_argument_o
  );

  always #4 clk_i = ~clk_i;

  // Signed divide truncating toward zero, wrapping on overflow
  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Execute one instruction on the shadow state, return the expected result
  function automatic exec_result_t execute_instr(logic [4:0] op, logic [4:0] d,
      logic [4:0] sa, logic [4:0] sb, logic [31:0] imm, logic [15:0] jt);
    exec_result_t r;
    logic [31:0] ra, rb, dv;
    logic [15:0] seq;
    ra  = shadow_regs[sa];
    rb  = shadow_regs[sb];
    seq = shadow_pc + 16'd1;
    r   = '0;
    r.status  = ST_DONE;
    r.next_pc = seq;
    case (op)
      OP_NOP: ;
      OP_LI: begin r.wrote = 1'b1; r.widx = d; r.wval = imm; end
      OP_ADD, OP_ADDU: begin r.wrote = 1'b1; r.widx = d; r.wval = ra + rb; end
      OP_ADDI, OP_ADDIU: begin r.wrote = 1'b1; r.widx = d; r.wval = ra + imm; end
      OP_SUB: begin r.wrote = 1'b1; r.widx = d; r.wval = ra - rb; end
      OP_MUL: begin r.wrote = 1'b1; r.widx = d; r.wval = ra * rb; end
      OP_MOVE: begin r.wrote = 1'b1; r.widx = d; r.wval = ra; end
      OP_SUBI: begin r.wrote = 1'b1; r.widx = d; r.wval = ra - imm; end
      OP_MULI: begin r.wrote = 1'b1; r.widx = d; r.wval = ra * imm; end
      OP_DIV, OP_DIVI: begin
        dv = (op == OP_DIV) ? rb : imm;
        if (dv == '0) begin
          r.status = ST_DIVZERO;
          r.next_pc = shadow_pc;
        end else begin
          r.wrote = 1'b1; r.widx = d; r.wval = div_trunc(ra, dv);
        end
      end
      OP_J: r.next_pc = jt;
      OP_JR: r.next_pc = ra[15:0];
      OP_JAL: begin
        // link is written before the target register is read
        shadow_regs[RegLink] = {16'd0, seq};
        r.wrote = 1'b1; r.widx = RegLink; r.wval = {16'd0, seq};
        r.next_pc = shadow_regs[sa][15:0];
      end
      OP_SYSCALL: begin
        r.status = ST_SYSCALL;
        r.scode = shadow_regs[RegService];
        r.sarg = shadow_regs[RegArgument];
      end
      default: begin r.status = ST_UNKNOWN; r.next_pc = shadow_pc; end
    endcase
    if (r.wrote && op != OP_JAL) shadow_regs[r.widx] = r.wval;
    shadow_pc = r.next_pc;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // Send one instruction beat, with a random gap before it
  task automatic send_instr(logic [4:0] op, logic [4:0] d, logic [4:0] sa,
      logic [4:0] sb, logic [31:0] imm, logic [15:0] jt);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op; dest_reg_i <= d; src_a_reg_i <= sa; src_b_reg_i <= sb;
    immediate_i <= imm; jump_target_i <= jt;
    do @(posedge clk_i); while (full);
    pending_results.push_back(execute_instr(op, d, sa, sb, imm, jt));
  endtask

  // Result side: random stalls, field-by-field check against oldest prediction
  initial begin : result_checker
    int unsigned stall;
    exec_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 5);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (next_pc_o !== want.next_pc)
          report_mismatch("next_pc", 32'(next_pc_o), 32'(want.next_pc));
        if (wrote_register_o !== want.wrote)
          report_mismatch("wrote_register", 32'(wrote_register_o), 32'(want.wrote));
        if (written_index_o !== want.widx)
          report_mismatch("written_index", 32'(written_index_o), 32'(want.widx));
        if (written_value_o !== want.wval)
          report_mismatch("written_value", written_value_o, want.wval);
        if (service_code_o !== want.scode)
          report_mismatch("service_code", service_code_o, want.scode);
        if (service_argument_o !== want.sarg)
          report_mismatch("service_argument", service_argument_o, want.sarg);
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_mips_like_instruction_executor: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Every operation, field extremes and the corner cases
  task automatic test_directed();
    send_instr(OP_LI, 5'd1, 0, 0, 32'h8000_0000, 0);
    send_instr(OP_LI, 5'd2, 0, 0, 32'hFFFF_FFFF, 0);
    send_instr(OP_DIV, 5'd3, 5'd1, 5'd2, 0, 0);        // overflow wraps
    send_instr(OP_DIV, 5'd3, 5'd1, 5'd5, 0, 0);        // zero divisor
    send_instr(OP_DIVI, 5'd3, 5'd1, 0, 32'd0, 0);      // zero immediate divisor
    send_instr(OP_DIVI, 5'd31, 5'd1, 0, 32'd7, 0);
    send_instr(OP_ADD, 5'd0, 5'd1, 5'd2, 0, 0);        // register 0 writable
    send_instr(OP_ADDI, 5'd4, 5'd0, 0, 32'h7FFF_FFFF, 0);
    send_instr(OP_ADDU, 5'd5, 5'd4, 5'd4, 0, 0);
    send_instr(OP_ADDIU, 5'd6, 5'd4, 0, 32'd1, 0);
    send_instr(OP_SUB, 5'd7, 5'd1, 5'd2, 0, 0);
    send_instr(OP_MUL, 5'd8, 5'd4, 5'd4, 0, 0);
    send_instr(OP_MOVE, 5'd9, 5'd8, 0, 0, 0);
    send_instr(OP_SUBI, 5'd10, 5'd9, 0, 32'h8000_0000, 0);
    send_instr(OP_MULI, 5'd11, 5'd10, 0, 32'hFFFF_FFFF, 0);
    send_instr(OP_SYSCALL, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
    send_instr(OP_J, 0, 0, 0, 0, 16'hFFFF);
    send_instr(OP_NOP, 0, 0, 0, 0, 0);                  // pc wraps to zero
    send_instr(OP_JR, 0, 5'd2, 0, 0, 0);
    send_instr(OP_JAL, 0, 5'd31, 0, 0, 0);              // link through r31
    send_instr(OP_JAL, 0, 5'd4, 0, 0, 0);
    send_instr(5'd17, 0, 0, 0, 0, 0);
    send_instr(5'd31, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
    send_instr(OP_LI, 5'd2, 0, 0, 32'd10, 0);
    send_instr(OP_SYSCALL, 0, 0, 0, 0, 0);
  endtask

  // Random stream, mostly known operations, some divides and unknown codes
  task automatic test_random(int unsigned n);
    logic [4:0] op;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: op = 5'($urandom_range(17, 31));
        1: op = $urandom_range(0, 1) ? OP_DIV : OP_DIVI;
        default: op = 5'($urandom_range(0, 16));
      endcase
      send_instr(op, 5'($urandom), 5'($urandom), 5'($urandom), rand_value(),
                 16'($urandom));
      if (i % 300 == 299) wait_drained();
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    shadow_pc = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(1430);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_mips_like_instruction_executor: done, clean");
    end else begin
      $display("tb_mips_like_instruction_executor: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mle_pkg.sv
hdl/mle_front.sv
hdl/mle_divider.sv
hdl/mle_back.sv
hdl/mips_like_instruction_executor.sv
tb/tb_mips_like_instruction_executor.sv
